// ===== src/mtwg_pkg.sv =====
// Shared constants and types of the MT19937 word generator.
package mtwg_pkg;

    localparam int unsigned WORD_W = 32;

    localparam logic [WORD_W-1:0] TWIST_MATRIX  = 32'h9908b0df;
    localparam logic [WORD_W-1:0] HIGH_BIT_MASK = 32'h80000000;
    localparam logic [WORD_W-1:0] LOW_BITS_MASK = 32'h7fffffff;
    localparam logic [WORD_W-1:0] TEMPER_MASK_B = 32'h9d2c5680;
    localparam logic [WORD_W-1:0] TEMPER_MASK_C = 32'hefc60000;
    localparam logic [WORD_W-1:0] SEED_MULT     = 32'd1812433253;
    localparam logic [WORD_W-1:0] SEED_RESET    = 32'h4141f00d;

    // Words read at fixed places of the state chain
    typedef struct packed {
        logic [WORD_W-1:0] head;    // oldest word
        logic [WORD_W-1:0] second;  // word after the oldest
        logic [WORD_W-1:0] tap;     // word at the tap offset
        logic [WORD_W-1:0] tail;    // newest word
    } t_taps;

    typedef struct packed {
        logic [WORD_W-1:0] next_word;  // word pushed into the chain
        logic [WORD_W-1:0] tempered;   // output word
    } t_twist;

endpackage

// ===== src/mtwg_chain.sv =====
// Row of state cells that shifts one word toward the head on each push.
module mtwg_chain #(
    parameter int unsigned DEPTH = 624,
    parameter int unsigned TAP   = 397
) (
    input  logic                       i_clk,
    input  logic                       i_shift,
    input  logic [mtwg_pkg::WORD_W-1:0] i_word,
    output mtwg_pkg::t_taps            o_taps
);

    logic [mtwg_pkg::WORD_W-1:0] r_cell [DEPTH];

    // Each cell takes its neighbor's word; the tail cell takes the new word
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        if (k == DEPTH - 1) begin : g_tail
            always_ff @(posedge i_clk) begin
                if (i_shift) begin
                    r_cell[k] <= i_word;
                end
            end
        end else begin : g_body
            always_ff @(posedge i_clk) begin
                if (i_shift) begin
                    r_cell[k] <= r_cell[k+1];
                end
            end
        end
    end

    // Fixed taps
    assign o_taps.head   = r_cell[0];
    assign o_taps.second = r_cell[1];
    assign o_taps.tap    = r_cell[TAP];
    assign o_taps.tail   = r_cell[DEPTH-1];

endmodule

// ===== src/mtwg_twist.sv =====
// Twist of the head word and tempering of the result.
module mtwg_twist (
    input  mtwg_pkg::t_taps  i_taps,
    output mtwg_pkg::t_twist o_twist
);

    logic [mtwg_pkg::WORD_W-1:0] y;
    logic [mtwg_pkg::WORD_W-1:0] mag;
    logic [mtwg_pkg::WORD_W-1:0] w;
    logic [mtwg_pkg::WORD_W-1:0] t1;
    logic [mtwg_pkg::WORD_W-1:0] t2;
    logic [mtwg_pkg::WORD_W-1:0] t3;

    // Combine upper bit of the head with lower bits of its neighbor
    assign y   = (i_taps.head & mtwg_pkg::HIGH_BIT_MASK)
               | (i_taps.second & mtwg_pkg::LOW_BITS_MASK);
    assign mag = y[0] ? mtwg_pkg::TWIST_MATRIX : '0;
    assign w   = i_taps.tap ^ (y >> 1) ^ mag;

    // Temper the new word
    assign t1 = w ^ (w >> 11);
    assign t2 = t1 ^ ((t1 << 7) & mtwg_pkg::TEMPER_MASK_B);
    assign t3 = t2 ^ ((t2 << 15) & mtwg_pkg::TEMPER_MASK_C);

    assign o_twist.next_word = w;
    assign o_twist.tempered  = t3 ^ (t3 >> 18);

endmodule

// ===== src/mersenne_twister_word_generator.sv =====
// MT19937 generator: after reset the first request seeds the 624-word state from the seed
// register by pushing one word a cycle into a chain of state cells (input stalled), then gives
// its word via the generate state and output register. From then on each request twists the
// head cell into a new tail word and returns its tempered value, so one word leaves per cycle,
// the rate of the chain shift, unless the output stalls. A registered output stage parts the
// two channels, so a new request is taken in the cycle the previous word is transferred.
module mersenne_twister_word_generator #(
    parameter int unsigned STATE_DEPTH = 624,
    parameter int unsigned TAP_OFFSET  = 397
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_seed_we,
    input  logic [mtwg_pkg::WORD_W-1:0] i_seed_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_request,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [mtwg_pkg::WORD_W-1:0] o_random_word
);

    localparam int unsigned CNT_W = $clog2(STATE_DEPTH);

    typedef enum logic [2:0] {
        ST_RUN  = 3'b001,
        ST_SEED = 3'b010,
        ST_GEN  = 3'b100
    } t_state;

    t_state                      r_state, n_state;
    logic                        r_seeded, n_seeded;
    logic [CNT_W-1:0]            r_seed_cnt, n_seed_cnt;
    logic [mtwg_pkg::WORD_W-1:0] r_seed;
    logic                        r_out_valid, n_out_valid;
    logic [mtwg_pkg::WORD_W-1:0] r_out_word, n_out_word;

    mtwg_pkg::t_taps             taps;
    mtwg_pkg::t_twist            twist;
    logic                        shift;
    logic [mtwg_pkg::WORD_W-1:0] shift_word;
    logic [mtwg_pkg::WORD_W-1:0] seed_mix;
    logic [mtwg_pkg::WORD_W-1:0] seed_word;
    logic                        out_room;
    logic                        in_xfer;

    mtwg_chain #(
        .DEPTH (STATE_DEPTH),
        .TAP   (TAP_OFFSET)
    ) u_chain (
        .i_clk   (i_clk),
        .i_shift (shift),
        .i_word  (shift_word),
        .o_taps  (taps)
    );

    mtwg_twist u_twist (
        .i_taps  (taps),
        .o_twist (twist)
    );

    // Handshake
    assign out_room   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_RUN) || !out_room;
    assign in_xfer    = i_in_valid && !o_in_stall;

    // Seeding recurrence on the newest word
    assign seed_mix  = taps.tail ^ (taps.tail >> 30);
    assign seed_word = mtwg_pkg::WORD_W'(mtwg_pkg::SEED_MULT * seed_mix)
                     + mtwg_pkg::WORD_W'(r_seed_cnt);

    // Sequence seeding and word generation
    always_comb begin
        n_state     = r_state;
        n_seeded    = r_seeded;
        n_seed_cnt  = r_seed_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_word  = r_out_word;
        shift       = 1'b0;
        shift_word  = twist.next_word;
        unique case (r_state)
            ST_RUN: begin
                if (in_xfer && i_request) begin
                    shift = 1'b1;
                    if (r_seeded) begin
                        n_out_valid = 1'b1;
                        n_out_word  = twist.tempered;
                    end else begin
                        shift_word = r_seed;
                        n_seed_cnt = CNT_W'(1);
                        n_state    = ST_SEED;
                    end
                end
            end
            ST_SEED: begin
                shift      = 1'b1;
                shift_word = seed_word;
                n_seed_cnt = r_seed_cnt + CNT_W'(1);
                if (r_seed_cnt == CNT_W'(STATE_DEPTH - 1)) begin
                    n_state = ST_GEN;
                end
            end
            ST_GEN: begin
                shift       = 1'b1;
                n_out_valid = 1'b1;
                n_out_word  = twist.tempered;
                n_seeded    = 1'b1;
                n_state     = ST_RUN;
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_seeded    <= 1'b0;
            r_seed_cnt  <= '0;
            r_out_valid <= 1'b0;
            r_seed      <= mtwg_pkg::SEED_RESET;
        end else begin
            r_state     <= n_state;
            r_seeded    <= n_seeded;
            r_seed_cnt  <= n_seed_cnt;
            r_out_valid <= n_out_valid;
            if (i_seed_we) begin
                r_seed <= i_seed_wdata;
            end
        end
    end

    // Output word
    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
    end

    assign o_out_valid   = r_out_valid;
    assign o_random_word = r_out_word;

    // Seeding happens only once after reset
    a_seed_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEED) |-> !r_seeded)
        else $error("seeding while already seeded");

    // Last seed push leads to the first generated word
    a_seed_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEED && r_seed_cnt == CNT_W'(STATE_DEPTH - 1)) |=> (r_state == ST_GEN))
        else $error("seeding did not end after the full state");

    // Generation after seeding finds the output stage empty and fills it
    a_gen_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_GEN) |-> !r_out_valid)
        else $error("output stage busy at end of seeding");

    a_gen_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_GEN) |=> (r_out_valid && r_seeded))
        else $error("no word after seeding");

    // A seeded request yields a word in the next cycle
    a_req_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_request && r_seeded) |=> r_out_valid)
        else $error("request lost");

endmodule

// ===== sim/mtwg_word_checker.sv =====
`timescale 1ns / 1ps
// Checker of the MT19937 word generator: predicts every requested word and compares transfers.
module mtwg_word_checker #(
    parameter int unsigned STATE_DEPTH = 624,
    parameter int unsigned TAP_OFFSET  = 397
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_seed_we,
    input  logic [mtwg_pkg::WORD_W-1:0] i_seed_wdata,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic                        i_request,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic [mtwg_pkg::WORD_W-1:0] i_random_word,
    output int                          o_fail_count,
    output int                          o_words_pending
);

    logic [mtwg_pkg::WORD_W-1:0] seed_word;
    logic [mtwg_pkg::WORD_W-1:0] mt_state [STATE_DEPTH];
    int unsigned                 read_pos;
    bit                          seeded;
    logic [mtwg_pkg::WORD_W-1:0] expected_words [$];
    int                          fail_total = 0;

    // Advance the generator by one word: seed on first use, twist when the state runs out
    function automatic logic [mtwg_pkg::WORD_W-1:0] next_word();
        logic [mtwg_pkg::WORD_W-1:0] prev;
        logic [mtwg_pkg::WORD_W-1:0] mixed;
        logic [mtwg_pkg::WORD_W-1:0] y;
        int unsigned                 nxt;
        int unsigned                 tap;
        if (!seeded) begin
            mt_state[0] = seed_word;
            for (int unsigned i = 1; i < STATE_DEPTH; i++) begin
                prev = mt_state[i-1];
                mt_state[i] = mtwg_pkg::SEED_MULT * (prev ^ (prev >> 30)) + i;
            end
            seeded   = 1'b1;
            read_pos = STATE_DEPTH;
        end
        // twist in place; taps past the wrap already hold new words
        if (read_pos >= STATE_DEPTH) begin
            for (int unsigned k = 0; k < STATE_DEPTH; k++) begin
                nxt   = (k + 1) % STATE_DEPTH;
                tap   = (k + TAP_OFFSET) % STATE_DEPTH;
                mixed = (mt_state[k] & mtwg_pkg::HIGH_BIT_MASK)
                      | (mt_state[nxt] & mtwg_pkg::LOW_BITS_MASK);
                mt_state[k] = mt_state[tap] ^ (mixed >> 1)
                            ^ (mixed[0] ? mtwg_pkg::TWIST_MATRIX : '0);
            end
            read_pos = 0;
        end
        y = mt_state[read_pos];
        read_pos++;
        // temper
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & mtwg_pkg::TEMPER_MASK_B);
        y = y ^ ((y << 15) & mtwg_pkg::TEMPER_MASK_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    // Track seed writes and requests, compare each output transfer with the oldest word due
    always @(posedge i_clk) begin : predict_and_compare
        logic [mtwg_pkg::WORD_W-1:0] want;
        if (!i_rst_n) begin
            seed_word = mtwg_pkg::SEED_RESET;
            read_pos  = 0;
            seeded    = 1'b0;
            expected_words.delete();
        end else begin
            // a seed write after seeding is stored but never used again
            if (i_seed_we) begin
                seed_word = i_seed_wdata;
            end
            if (i_in_valid && !i_in_stall && i_request) begin
                expected_words.push_back(next_word());
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: random_word transfer with none expected, got %h",
                             $time, i_random_word);
                    fail_total++;
                end else begin
                    want = expected_words.pop_front();
                    if (i_random_word !== want) begin
                        $display("%0t: random_word mismatch, expected %h, got %h",
                                 $time, want, i_random_word);
                        fail_total++;
                    end
                end
            end
        end
        o_fail_count    <= fail_total;
        o_words_pending <= expected_words.size();
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top of the MT19937 word generator: clock, reset, stimulus and verdict.
module tb_top;

    localparam int unsigned STATE_DEPTH  = 624;
    localparam int unsigned TAP_OFFSET   = 397;
    localparam int unsigned RANDOM_ITEMS = 480;
    localparam int unsigned PHASES       = 4;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam logic        REQ_NONE     = 1'b0;
    localparam logic        REQ_WORD     = 1'b1;

    logic                        i_clk        = 1'b0;
    logic                        i_rst_n      = 1'b0;
    logic                        i_seed_we    = 1'b0;
    logic [mtwg_pkg::WORD_W-1:0] i_seed_wdata = '0;
    logic                        i_in_valid   = 1'b0;
    logic                        i_request    = REQ_NONE;
    logic                        i_out_stall  = 1'b0;
    logic                        o_in_stall;
    logic                        o_out_valid;
    logic [mtwg_pkg::WORD_W-1:0] o_random_word;

    int          fail_count;
    int          words_pending;
    int unsigned cycle_count = 0;
    int unsigned stall_left  = 0;
    bit          calm        = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    mersenne_twister_word_generator #(
        .STATE_DEPTH (STATE_DEPTH),
        .TAP_OFFSET  (TAP_OFFSET)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_seed_we     (i_seed_we),
        .i_seed_wdata  (i_seed_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_request     (i_request),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_random_word (o_random_word)
    );

    mtwg_word_checker #(
        .STATE_DEPTH (STATE_DEPTH),
        .TAP_OFFSET  (TAP_OFFSET)
    ) i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_seed_we       (i_seed_we),
        .i_seed_wdata    (i_seed_wdata),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_request       (i_request),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_random_word   (o_random_word),
        .o_fail_count    (fail_count),
        .o_words_pending (words_pending)
    );

    // Stall the output side in random bursts, mostly short, none while calm
    always @(posedge i_clk) begin : out_stall_gen
        int unsigned pick;
        if (calm) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                i_out_stall <= 1'b0;
            end else if (pick < 95) begin
                i_out_stall <= 1'b1;
                stall_left  <= $urandom_range(0, 2);
            end else begin
                i_out_stall <= 1'b1;
                stall_left  <= $urandom_range(10, 40);
            end
        end
    end

    // Drop the run if it hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int unsigned draw_gap();
        int unsigned pick;
        if (calm) begin
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            return 0;
        end
        if (pick < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Offer one request and hold it until the transfer; valid stays high unless a gap follows
    task automatic send_item(input logic req);
        int unsigned gap;
        i_in_valid <= 1'b1;
        i_request  <= req;
        do @(posedge i_clk); while (o_in_stall);
        gap = draw_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_seed(input logic [mtwg_pkg::WORD_W-1:0] value);
        i_seed_we    <= 1'b1;
        i_seed_wdata <= value;
        @(posedge i_clk);
        i_seed_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Pause the sender until every predicted word has come out, then let the block settle
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (words_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [mtwg_pkg::WORD_W-1:0] first_seed;
        logic [mtwg_pkg::WORD_W-1:0] phase_seed;
        case ($urandom_range(0, 3))
            0:       first_seed = '0;
            1:       first_seed = '1;
            2:       first_seed = mtwg_pkg::SEED_RESET;
            default: first_seed = $urandom;
        endcase
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // last seed write before the first request wins
        write_seed(~first_seed);
        write_seed(first_seed);
        // an idle request must not start seeding
        send_item(REQ_NONE);
        send_item(REQ_WORD);
        send_item(REQ_NONE);
        // back-to-back words with no idling on either side
        calm = 1'b1;
        repeat (16) send_item(REQ_WORD);
        calm = 1'b0;
        send_item(REQ_NONE);
        repeat (4) send_item(REQ_WORD);
        wait_drained();
        // a seed change after seeding leaves the sequence alone
        write_seed(~first_seed);

        // random phases, each followed by a seed write that must not disturb the sequence
        for (int phase = 0; phase < PHASES; phase++) begin
            calm = (phase == 1);
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
                send_item(($urandom_range(0, 9) == 0) ? REQ_NONE : REQ_WORD);
            end
            calm = 1'b0;
            wait_drained();
            case (phase)
                0:       phase_seed = '1;
                1:       phase_seed = '0;
                2:       phase_seed = $urandom;
                default: phase_seed = mtwg_pkg::SEED_RESET;
            endcase
            write_seed(phase_seed);
        end

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/mtwg_pkg.sv
src/mtwg_chain.sv
src/mtwg_twist.sv
src/mersenne_twister_word_generator.sv
sim/mtwg_word_checker.sv
sim/tb_top.sv
